@@ sv/lbpg_pkg.sv @@
`timescale 1ns / 1ps

package lbpg_pkg;

  // Number of blink channels held in the bank.
  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of one item.
  localparam int MODE_W = 2;
  localparam int CHAN_W = 3;
  localparam int CNT_W  = 16;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat
    logic commit;  // update the channel and load the output register
  } lbpg_cmd_t;

endpackage

@@ sv/lbpg_ctrl.sv @@
`timescale 1ns / 1ps

module lbpg_ctrl
  import lbpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lbpg_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Accept in idle; commit once the output register is free or being drained.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A captured beat is always followed by the calculation step.
  a_load_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_CALC)
    else $error("load not followed by calculation");

  // A result never overwrites one that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while output register is held");

  // Every commit presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not raise output valid");

endmodule

@@ sv/lbpg_datapath.sv @@
`timescale 1ns / 1ps

module lbpg_datapath
  import lbpg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbpg_cmd_t         cmd_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [CNT_W-1:0]  on_ticks_i,
  input  logic [CNT_W-1:0]  off_ticks_i,
  input  logic [CNT_W-1:0]  repeat_count_i,
  output logic [CHAN_W-1:0] out_channel_o,
  output logic              lamp_on_o,
  output logic              active_o
);

  // Captured item.
  logic [MODE_W-1:0] mode_q;
  logic [CHAN_W-1:0] chan_q;
  logic [CNT_W-1:0]  on_q, off_q, rep_q;

  // Per-channel state.
  logic             enabled_q [CHANNELS];
  logic             phase_q   [CHANNELS];
  logic             lamp_q    [CHANNELS];
  logic [CNT_W-1:0] on_len_q  [CHANNELS];
  logic [CNT_W-1:0] off_len_q [CHANNELS];
  logic [CNT_W-1:0] limit_q   [CHANNELS];
  logic [CNT_W-1:0] tick_q    [CHANNELS];
  logic [CNT_W-1:0] period_q  [CHANNELS];

  // Output register.
  logic [CHAN_W-1:0] out_chan_q;
  logic              out_lamp_q, out_active_q;

  logic [CH_IDX_W-1:0] idx;
  logic                in_range;
  logic                nx_en, nx_ph, nx_lamp;
  logic [CNT_W-1:0]    nx_on, nx_off, nx_lim, nx_tick, nx_per;
  logic [CNT_W-1:0]    tick_inc, per_inc;

  assign idx      = CH_IDX_W'(chan_q);
  assign in_range = (32'(chan_q) < CHANNELS);
  assign tick_inc = tick_q[idx] + 1'b1;
  assign per_inc  = period_q[idx] + 1'b1;

  // Next state of the addressed channel.
  always_comb begin
    nx_en   = enabled_q[idx];
    nx_ph   = phase_q[idx];
    nx_lamp = lamp_q[idx];
    nx_on   = on_len_q[idx];
    nx_off  = off_len_q[idx];
    nx_lim  = limit_q[idx];
    nx_tick = tick_q[idx];
    nx_per  = period_q[idx];
    case (mode_q)
      MODE_TICK: begin
        if (enabled_q[idx] && (off_len_q[idx] != '0)) begin
          nx_tick = tick_inc;
          if (!phase_q[idx]) begin
            // End of the on phase turns the lamp off.
            if (tick_inc >= on_len_q[idx]) begin
              nx_lamp = 1'b0;
              nx_tick = '0;
              nx_ph   = 1'b1;
            end
          end else if (tick_inc >= off_len_q[idx]) begin
            if ((limit_q[idx] != '0) && (per_inc >= limit_q[idx])) begin
              // Last period done: disable with the lamp off.
              nx_per = per_inc;
              nx_en  = 1'b0;
              nx_off = '0;
            end else begin
              if (limit_q[idx] != '0) begin
                nx_per = per_inc;
              end
              nx_tick = '0;
              nx_ph   = 1'b0;
              nx_lamp = 1'b1;
            end
          end
        end
      end
      MODE_START: begin
        if (on_q != '0) begin
          nx_on   = on_q;
          nx_off  = off_q;
          nx_lim  = rep_q;
          nx_tick = '0;
          nx_per  = '0;
          nx_ph   = 1'b0;
          nx_en   = 1'b1;
          nx_lamp = 1'b1;
        end
      end
      MODE_STOP: begin
        nx_on   = '0;
        nx_off  = '0;
        nx_lim  = '0;
        nx_tick = '0;
        nx_per  = '0;
        nx_ph   = 1'b0;
        nx_en   = 1'b0;
        nx_lamp = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Item capture on an accepted input beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      chan_q <= channel_i;
      on_q   <= on_ticks_i;
      off_q  <= off_ticks_i;
      rep_q  <= repeat_count_i;
    end
  end

  // Control bits of each channel, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        enabled_q[c] <= 1'b0;
        phase_q[c]   <= 1'b0;
        lamp_q[c]    <= 1'b0;
      end
    end else if (cmd_i.commit && in_range) begin
      enabled_q[idx] <= nx_en;
      phase_q[idx]   <= nx_ph;
      lamp_q[idx]    <= nx_lamp;
    end
  end

  // Lengths and counters; only looked at while the channel is enabled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && in_range) begin
      on_len_q[idx]  <= nx_on;
      off_len_q[idx] <= nx_off;
      limit_q[idx]   <= nx_lim;
      tick_q[idx]    <= nx_tick;
      period_q[idx]  <= nx_per;
    end
  end

  // Output register holds the result beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_chan_q   <= chan_q;
      out_lamp_q   <= in_range & nx_lamp;
      out_active_q <= in_range & nx_en;
    end
  end

  assign out_channel_o = out_chan_q;
  assign lamp_on_o     = out_lamp_q;
  assign active_o      = out_active_q;

endmodule

@@ sv/led_blink_pattern_generator.sv @@
`timescale 1ns / 1ps

// Bank of blink channels driven by a stream of items.
// Input channel (in_valid_i / in_ready_o): one beat carries mode, channel,
// on_ticks, off_ticks and repeat_count. Mode tick advances the addressed
// channel's pattern, start loads and lights it if on_ticks>0, stop clears it.
// Output channel (out_valid_o / out_ready_i): one beat per input beat with
// the channel number, its lamp level and whether its pattern is active.
// An item is handled in two steps: the beat is captured, then the channel
// registers get their read-modify-write. A new item is accepted only after
// the last one has been committed. The result sits in an output register;
// the next item is accepted while it waits, but its update is held until
// that register is drained, so a stalled receiver backs up the input after
// one more beat.
// Reset disables all channels with their lamps off and empties the output.
module led_blink_pattern_generator
  import lbpg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [CNT_W-1:0]  on_ticks_i,
  input  logic [CNT_W-1:0]  off_ticks_i,
  input  logic [CNT_W-1:0]  repeat_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] out_channel_o,
  output logic              lamp_on_o,
  output logic              active_o
);

  lbpg_cmd_t cmd;

  // Sequencing of capture and commit.
  lbpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Channel registers and the pattern update.
  lbpg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .channel_i      (channel_i),
    .on_ticks_i     (on_ticks_i),
    .off_ticks_i    (off_ticks_i),
    .repeat_count_i (repeat_count_i),
    .out_channel_o  (out_channel_o),
    .lamp_on_o      (lamp_on_o),
    .active_o       (active_o)
  );

endmodule
